@@ src/text_console_cell_writer_defines.svh @@
// Assertion macros shared by the console RTL. They sample on i_clk and
// are held off while i_rst_n is low.
`ifndef TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
`define TCCW_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("console check failed");
`define TCCW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("console check failed");
`define TCCW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("console check failed");
`else
`define TCCW_ASSERT(lbl, cond)
`define TCCW_ASSERT_IMP(lbl, ante, cons)
`define TCCW_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ src/tccw_pkg.sv @@
package tccw_pkg;

    localparam int REQ_TYPE_W   = 2;
    localparam int CHAR_W       = 8;
    localparam int CELL_INDEX_W = 11;
    localparam int CURSOR_POS_W = 11;
    localparam int CELL_W       = 16;
    localparam int COLOR_W      = 4;
    localparam int CFG_IDX_W    = 2;

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;

    // control characters
    localparam logic [CHAR_W-1:0] KEY_BS     = 8'd8;
    localparam logic [CHAR_W-1:0] KEY_TAB    = 8'd9;
    localparam logic [CHAR_W-1:0] KEY_LF     = 8'd10;
    localparam logic [CHAR_W-1:0] KEY_CR     = 8'd13;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'hf;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]   req_type;
        logic [CHAR_W-1:0]       char_code;
        logic [CELL_INDEX_W-1:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [CURSOR_POS_W-1:0] cursor_pos;
        logic [CELL_W-1:0]       cell_data;
    } t_out_item;

    typedef struct packed {
        logic load;       // capture the request
        logic exec;       // apply a put to cursor and cell store
        logic rd_cell;    // issue the read of a requested cell
        logic copy;       // scroll: move one cell up a row
        logic fill;       // scroll: blank one bottom-row cell
        logic wipe;       // zero one cell
        logic home;       // cursor to the origin
        logic sweep_inc;
        logic sweep_clr;
        logic out_load;   // load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic need_scroll;
        logic copy_end;
        logic sweep_end;
        logic sweep_zero;
    } t_dp_sts;

endpackage

@@ src/tccw_dp.sv @@
`include "text_console_cell_writer_defines.svh"

module tccw_dp #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tccw_pkg::t_dp_cmd                   i_cmd,
    output tccw_pkg::t_dp_sts                   o_sts,
    input  tccw_pkg::t_in_item                  i_in_item,
    output tccw_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tccw_pkg::COLOR_W-1:0]        i_cfg_data
);
    import tccw_pkg::*;

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int COPY_CELLS = COLUMNS * (ROWS - 1);
    localparam int AW         = $clog2(CELLS);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int CX_W       = $clog2(COLUMNS + TAB_STOP);
    localparam int RX_W       = $clog2(ROWS + 1);
    localparam int REM_W      = $clog2(TAB_STOP);
    localparam int CNT_W      = $clog2(CELLS + 1);
    localparam int CMP_W      = (CNT_W > CELL_INDEX_W) ? CNT_W : CELL_INDEX_W;

    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [REM_W-1:0]   r_rem;      // column modulo the tab stop
    logic [COLOR_W-1:0] r_fg;
    logic [COLOR_W-1:0] r_bg;
    logic [AW-1:0]      r_sweep;
    t_in_item           r_req;
    t_out_item          r_out;
    logic [CELL_W-1:0]  r_rd_data;
    logic [CELL_W-1:0]  r_mem [CELLS];

    logic [CX_W-1:0]    col_x;
    logic [RX_W-1:0]    row_x;
    logic [REM_W-1:0]   rem_n;
    logic               put_wr;
    logic               need_scroll;
    logic [7:0]         attr;
    logic [AW-1:0]      cur_lin;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [CELL_W-1:0]  wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               copy_end;
    logic               sweep_end;
    logic               rd_hit;

    assign attr      = {r_bg, r_fg};
    assign cur_lin   = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign copy_end  = (r_sweep == AW'(COPY_CELLS));
    assign sweep_end = (r_sweep == AW'(CELLS - 1));
    assign rd_hit    = (r_req.req_type == REQ_READ) &&
                       (CMP_W'(r_req.cell_index) < CMP_W'(CELLS));

    assign o_sts.need_scroll = need_scroll;
    assign o_sts.copy_end    = copy_end;
    assign o_sts.sweep_end   = sweep_end;
    assign o_sts.sweep_zero  = (r_sweep == '0);
    assign o_out_item        = r_out;

    // next cursor for a put
    always_comb begin
        col_x  = CX_W'(r_col);
        row_x  = RX_W'(r_row);
        rem_n  = r_rem;
        put_wr = 1'b0;
        unique case (r_req.char_code)
            KEY_BS: begin
                if (r_col != '0) begin
                    col_x = CX_W'(r_col) - CX_W'(1);
                    rem_n = (r_rem == '0) ? REM_W'(TAB_STOP - 1) : r_rem - REM_W'(1);
                end
            end
            KEY_TAB: begin
                col_x = CX_W'(r_col) + CX_W'(TAB_STOP) - CX_W'(r_rem);
                rem_n = '0;
            end
            KEY_LF: begin
                row_x = RX_W'(r_row) + RX_W'(1);
                col_x = '0;
                rem_n = '0;
            end
            KEY_CR: begin
                col_x = '0;
                rem_n = '0;
            end
            default: begin
                put_wr = 1'b1;
                col_x  = CX_W'(r_col) + CX_W'(1);
                rem_n  = (r_rem == REM_W'(TAB_STOP - 1)) ? '0 : r_rem + REM_W'(1);
            end
        endcase
        // wrap past the last column
        if (col_x >= CX_W'(COLUMNS)) begin
            col_x = '0;
            rem_n = '0;
            row_x = row_x + RX_W'(1);
        end
        need_scroll = (row_x >= RX_W'(ROWS));
        if (need_scroll) begin
            row_x = RX_W'(ROWS - 1);
        end
    end

    // cell store write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_sweep;
        wr_data = '0;
        priority if (i_cmd.exec) begin
            wr_en   = put_wr;
            wr_addr = cur_lin;
            wr_data = {attr, r_req.char_code};
        end else if (i_cmd.copy) begin
            // the write stores the cell read in the previous cycle
            wr_en   = (r_sweep != '0);
            wr_addr = r_sweep - AW'(1);
            wr_data = r_rd_data;
        end else if (i_cmd.fill) begin
            wr_en   = 1'b1;
            wr_data = {attr, BLANK_CHAR};
        end else if (i_cmd.wipe) begin
            wr_en   = 1'b1;
        end else begin
            wr_en   = 1'b0;
        end
    end

    // cell store read port
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_sweep + AW'(COLUMNS);
        priority if (i_cmd.rd_cell) begin
            rd_en   = 1'b1;
            rd_addr = AW'(r_req.cell_index);
        end else if (i_cmd.copy) begin
            rd_en   = !copy_end;
        end else begin
            rd_en   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_rem   <= '0;
            r_fg    <= FG_RESET;
            r_bg    <= BG_RESET;
            r_sweep <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_FG:  r_fg <= i_cfg_data;
                    CFG_BG:  r_bg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                r_col <= COL_W'(col_x);
                r_row <= ROW_W'(row_x);
                r_rem <= rem_n;
            end else if (i_cmd.home) begin
                r_col <= '0;
                r_row <= '0;
                r_rem <= '0;
            end
            if (i_cmd.sweep_clr) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep_inc) begin
                r_sweep <= r_sweep + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_item;
        end
        if (i_cmd.out_load) begin
            r_out.cursor_pos <= CURSOR_POS_W'(cur_lin);
            r_out.cell_data  <= rd_hit ? r_rd_data : '0;
        end
    end

    `TCCW_ASSERT(a_cursor_range, (r_col < COLUMNS) && (r_row < ROWS))
    `TCCW_ASSERT(a_rem_range, r_rem < TAB_STOP)
    `TCCW_ASSERT_IMP(a_copy_target, i_cmd.copy && wr_en, wr_addr < AW'(COPY_CELLS))

endmodule

@@ src/tccw_ctrl.sv @@
`include "text_console_cell_writer_defines.svh"

module tccw_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic [tccw_pkg::REQ_TYPE_W-1:0]     i_req_type,
    input  logic                                i_out_ready,
    input  tccw_pkg::t_dp_sts                   i_sts,
    output tccw_pkg::t_dp_cmd                   o_cmd,
    output logic                                o_in_ready,
    output logic                                o_out_valid
);
    import tccw_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_COPY,
        ST_FILL,
        ST_CLEAR,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                // clear the store after reset
                o_cmd.wipe = 1'b1;
                if (i_sts.sweep_end) begin
                    o_cmd.sweep_clr = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.sweep_inc = 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_req_type)
                        REQ_PUT:   n_state = ST_EXEC;
                        REQ_CLEAR: n_state = ST_CLEAR;
                        REQ_READ:  n_state = ST_READ;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.need_scroll ? ST_COPY : ST_DONE;
            end
            ST_READ: begin
                o_cmd.rd_cell = 1'b1;
                n_state       = ST_DONE;
            end
            ST_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_sts.copy_end) begin
                    n_state = ST_FILL;
                end else begin
                    o_cmd.sweep_inc = 1'b1;
                end
            end
            ST_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.sweep_end) begin
                    o_cmd.sweep_clr = 1'b1;
                    n_state         = ST_DONE;
                end else begin
                    o_cmd.sweep_inc = 1'b1;
                end
            end
            ST_CLEAR: begin
                o_cmd.wipe = 1'b1;
                o_cmd.home = 1'b1;
                if (i_sts.sweep_end) begin
                    o_cmd.sweep_clr = 1'b1;
                    n_state         = ST_DONE;
                end else begin
                    o_cmd.sweep_inc = 1'b1;
                end
            end
            ST_DONE: begin
                // hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `TCCW_ASSERT_IMP(a_no_overrun, o_cmd.out_load, !r_out_valid || i_out_ready)
    `TCCW_ASSERT_IMP(a_idle_sweep_home, r_state == ST_IDLE, i_sts.sweep_zero)
    `TCCW_ASSERT_NXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

endmodule

@@ src/text_console_cell_writer.sv @@
// Text console: a ROWS x COLUMNS store of 16-bit cells (attribute high byte,
// character low byte) with a cursor. Put, clear and read requests arrive as
// transactions and each returns one result with the linear cursor position.
// A put that needs no scroll (printable or control code) runs the execute
// and done states, a read the read and done states, and a request with the
// unused code the done state alone. A result that is not taken holds the
// next request off. A put that runs off the last row scrolls the screen one
// cell per cycle: it moves each cell up a row, reading one cell and writing
// another, then blanks the bottom row. A clear sweeps the store, and after
// reset a clearing pass runs before the first request is taken. Colour
// registers may be written at any time the block is idle; the write port is
// always ready.
module text_console_cell_writer #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  tccw_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output tccw_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tccw_pkg::COLOR_W-1:0]        i_cfg_data
);
    import tccw_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    tccw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_in_item.req_type),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    tccw_dp #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
